>>> rtl/core/frame_mean_stacker_defines.svh
// ----------------------------------------------------------------------------
// frame_mean_stacker_defines.svh
// Assertion macros shared by the frame mean stacker.
// ----------------------------------------------------------------------------
`ifndef FRAME_MEAN_STACKER_DEFINES_SVH
`define FRAME_MEAN_STACKER_DEFINES_SVH

// Concurrent check on clk, muted while reset is held
`define FMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk that also holds during reset
`define FMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg
// Types and constants of the frame mean stacker.
// ----------------------------------------------------------------------------
`default_nettype none

package fms_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned NFR_W   = 9;
  localparam int unsigned FIDX_W  = 8;
  localparam int unsigned PIXC_W  = 21;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // register decode on paddr[2]
  localparam logic REG_FRAMES = 1'b0;
  localparam logic REG_PIXELS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_cnt;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_frame;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/fms_ifs.sv
// ----------------------------------------------------------------------------
// fms_ifs
// Valid/ready channels for incoming pixels and averaged pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface fms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       abandon;

  modport source (output valid, red, green, blue, abandon, input ready);
  modport sink   (input valid, red, green, blue, abandon, output ready);
endinterface

interface fms_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mean_pixel;
  logic        last_pixel;

  modport source (output valid, mean_pixel, last_pixel, input ready);
  modport sink   (input valid, mean_pixel, last_pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/core/frame_mean_stacker.sv
// Handling: a pixel is captured in IDLE and its sum committed in SUM; on the
//   last frame its averaged word is offered in OUT after 16 steps of the shared divider.
// Flow: a new pixel is taken only once the last one is through; during the last
//   frame that also waits for the divider and for the word to be taken.
// Reset: counters clear, registers return to N=2 and 1048576 pixels; the
//   frame store is not cleared and is written by the first frame.
// ----------------------------------------------------------------------------
// frame_mean_stacker
// Per-pixel mean of N RGB frames using an integer frame store of sums.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frame_mean_stacker_defines.svh"

module frame_mean_stacker #(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  fms_in_if.sink                                in_if,
  fms_out_if.source                             out_if,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fms_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [fms_pkg::PDATA_W-1:0]      pwdata,
  output logic [fms_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);
  import fms_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PIXELS);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = (PW > PIXC_W) ? PW : PIXC_W;

  logic [NFR_W-1:0]  frames_r;
  logic [PIXC_W-1:0] pixels_r;
  logic [NFR_W-1:0]  n_eff;
  logic [CW-1:0]     pix_ext;
  logic [PW-1:0]     p_eff;
  logic              cfg_wr;
  cmd_t              cmd;
  status_t           status;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= NFR_W'(2);
      pixels_r <= PIXC_W'(1048576);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAMES: frames_r <= pwdata[NFR_W-1:0];
        REG_PIXELS: pixels_r <= pwdata[PIXC_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAMES: prdata = PDATA_W'(frames_r);
      REG_PIXELS: prdata = PDATA_W'(pixels_r);
      default:    prdata = '0;
    endcase
  end

  // clamp registers to their working ranges
  always_comb begin
    if (frames_r < NFR_W'(2))        n_eff = NFR_W'(2);
    else if (frames_r > NFR_W'(256)) n_eff = NFR_W'(256);
    else                             n_eff = frames_r;
  end

  assign pix_ext = CW'(pixels_r);

  always_comb begin
    if (pix_ext == '0)                 p_eff = PW'(1);
    else if (pix_ext > CW'(MAX_PIXELS)) p_eff = PW'(MAX_PIXELS);
    else                               p_eff = PW'(pix_ext);
  end

  fms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_abandon (in_if.abandon),
    .in_ready   (in_if.ready),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .cmd        (cmd),
    .status     (status)
  );

  fms_dp #(
    .AW (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .red        (in_if.red),
    .green      (in_if.green),
    .blue       (in_if.blue),
    .n_eff      (n_eff),
    .p_eff      (p_eff),
    .mean_pixel (out_if.mean_pixel),
    .last_pixel (out_if.last_pixel)
  );

  // checks
  `FMS_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
  `FMS_ASSERT(a_no_overlap, !(in_if.ready && out_if.valid), "ready while word pending")
  `FMS_ASSERT(a_out_drop, (out_if.valid && out_if.ready) |=> !out_if.valid, "word repeated")
  `FMS_ASSERT(a_busy_after_take, (in_if.valid && in_if.ready && !in_if.abandon) |=> !in_if.ready, "second pixel taken while busy")
  `FMS_ASSERT(a_div_only_last, status.div_done |-> !in_if.ready, "divider finished outside a pixel")

endmodule

`default_nettype wire

>>> rtl/core/fms_div.sv
// ----------------------------------------------------------------------------
// fms_div
// Radix-2 restoring divider, three channel sums by the frame count at once.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [fms_pkg::SUM_W-1:0]     sum_r_in,
  input  wire logic [fms_pkg::SUM_W-1:0]     sum_g_in,
  input  wire logic [fms_pkg::SUM_W-1:0]     sum_b_in,
  input  wire logic [fms_pkg::NFR_W-1:0]     divisor,
  output logic                               done,
  output logic [3*fms_pkg::CH_W-1:0]         quot
);
  import fms_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NFR_W-1:0]     dsr_r;
  logic [SUM_W-1:0]     dvd_r [3];
  logic [SUM_W-1:0]     dvd_nxt [3];
  logic [NFR_W-1:0]     rem_r [3];
  logic [NFR_W-1:0]     rem_nxt [3];
  logic [NFR_W:0]       trial [3];

  // one quotient bit per channel per cycle
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], dvd_r[c][SUM_W-1]};
      if (trial[c] >= {1'b0, dsr_r}) begin
        rem_nxt[c] = NFR_W'(trial[c] - {1'b0, dsr_r});
        dvd_nxt[c] = {dvd_r[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = trial[c][NFR_W-1:0];
        dvd_nxt[c] = {dvd_r[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  // step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r    <= divisor;
      dvd_r[0] <= sum_r_in;
      dvd_r[1] <= sum_g_in;
      dvd_r[2] <= sum_b_in;
      for (int c = 0; c < 3; c++) rem_r[c] <= '0;
    end else if (busy_r) begin
      for (int c = 0; c < 3; c++) begin
        dvd_r[c] <= dvd_nxt[c];
        rem_r[c] <= rem_nxt[c];
      end
    end
  end

  assign done = done_r;
  assign quot = {dvd_r[0][CH_W-1:0], dvd_r[1][CH_W-1:0], dvd_r[2][CH_W-1:0]};

endmodule

`default_nettype wire

>>> rtl/core/fms_dp.sv
// ----------------------------------------------------------------------------
// fms_dp
// Datapath: frame store, pixel and frame counters, sum update, divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_dp #(
  parameter int unsigned AW = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fms_pkg::cmd_t              cmd,
  output fms_pkg::status_t                status,
  input  wire logic [fms_pkg::CH_W-1:0]   red,
  input  wire logic [fms_pkg::CH_W-1:0]   green,
  input  wire logic [fms_pkg::CH_W-1:0]   blue,
  input  wire logic [fms_pkg::NFR_W-1:0]  n_eff,
  input  wire logic [AW:0]                p_eff,
  output logic [31:0]                     mean_pixel,
  output logic                            last_pixel
);
  import fms_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  logic [3*SUM_W-1:0] mem [DEPTH];
  logic [3*SUM_W-1:0] rdata_r;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [FIDX_W-1:0]  frame_r, frame_nxt;
  logic [CH_W-1:0]    red_r, green_r, blue_r;
  logic               last_r;
  logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic               end_of_frame;
  logic               div_done;
  logic [3*CH_W-1:0]  quot;

  // clamp the position into the frame for addressing
  always_comb begin
    if ({1'b0, pos_r} >= p_eff) rd_addr = AW'(p_eff - 1'b1);
    else                        rd_addr = pos_r;
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata_r <= mem[rd_addr];
      addr_r  <= rd_addr;
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
    end
    if (cmd.commit) mem[addr_r] <= {sum_r, sum_g, sum_b};
  end

  // first frame overwrites, later frames accumulate
  always_comb begin
    if (frame_r == '0) begin
      sum_r = SUM_W'(red_r);
      sum_g = SUM_W'(green_r);
      sum_b = SUM_W'(blue_r);
    end else begin
      sum_r = rdata_r[3*SUM_W-1:2*SUM_W] + SUM_W'(red_r);
      sum_g = rdata_r[2*SUM_W-1:SUM_W]   + SUM_W'(green_r);
      sum_b = rdata_r[SUM_W-1:0]         + SUM_W'(blue_r);
    end
  end

  assign status.last_frame = {1'b0, frame_r} >= (n_eff - 1'b1);
  assign end_of_frame      = ({1'b0, pos_r} + 1'b1) >= p_eff;
  assign status.div_done   = div_done;

  // counters
  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    if (cmd.clear_cnt) begin
      pos_nxt   = '0;
      frame_nxt = '0;
    end else if (cmd.commit) begin
      if (end_of_frame) begin
        pos_nxt   = '0;
        frame_nxt = status.last_frame ? '0 : frame_r + 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      frame_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) last_r <= end_of_frame;
  end

  fms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.commit && status.last_frame),
    .sum_r_in (sum_r),
    .sum_g_in (sum_g),
    .sum_b_in (sum_b),
    .divisor  (n_eff),
    .done     (div_done),
    .quot     (quot)
  );

  assign mean_pixel = {ALPHA_OPAQUE, quot};
  assign last_pixel = last_r;

endmodule

`default_nettype wire

>>> rtl/core/fms_ctrl.sv
// ----------------------------------------------------------------------------
// fms_ctrl
// Controller: sequences capture, accumulate, divide and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_abandon,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fms_pkg::cmd_t          cmd,
  input  wire fms_pkg::status_t  status
);
  import fms_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && !in_abandon) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = status.last_frame ? ST_DIV : ST_IDLE;
      ST_DIV:  if (status.div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.capture   = in_valid && !in_abandon;
        cmd.clear_cnt = in_valid && in_abandon;
      end
      ST_SUM:  cmd.commit = 1'b1;
      ST_DIV:  ;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

>>> tb/fms_checker.sv
// ----------------------------------------------------------------------------
// fms_checker
// Watches the pixel, result and register ports of the frame mean stacker.
// Keeps its own copy of the sum store, counters and registers, predicts each
// averaged word and compares every accepted result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fms_checker (
  input  logic        clk,
  input  logic        rst_n,
  fms_in_if           in_if,
  fms_out_if          out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [31:0] mean_pixel;
    logic        last_pixel;
  } mean_word_t;

  mean_word_t   mean_q[$];
  logic [47:0]  sum_store [int];
  logic [8:0]   frames_reg;
  logic [20:0]  pixels_reg;
  int unsigned  pix_pos;
  int unsigned  frame_idx;

  assign pending = mean_q.size();

  // one accepted pixel through the stacking model
  task automatic stack_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic ab);
    int unsigned n_frames;
    int unsigned n_pix;
    int unsigned slot;
    logic [15:0] sr, sg, sb;
    logic [47:0] old;
    logic        last_frame, end_frame;
    mean_word_t  w;
    n_frames = (frames_reg < 2) ? 2 : (frames_reg > 256) ? 256 : frames_reg;
    n_pix    = (pixels_reg == 0) ? 1 : (pixels_reg > 1048576) ? 1048576 : pixels_reg;
    if (ab) begin
      pix_pos   = 0;
      frame_idx = 0;
      return;
    end
    slot = (pix_pos >= n_pix) ? n_pix - 1 : pix_pos;
    slot = slot & 32'hfffff;
    if (frame_idx == 0) begin
      sr = 16'(r); sg = 16'(g); sb = 16'(b);
    end else begin
      old = sum_store.exists(slot) ? sum_store[slot] : 48'd0;
      sr = old[47:32] + 16'(r);
      sg = old[31:16] + 16'(g);
      sb = old[15:0] + 16'(b);
    end
    sum_store[slot] = {sr, sg, sb};
    last_frame = (frame_idx >= n_frames - 1);
    end_frame  = (pix_pos + 1 >= n_pix);
    if (last_frame) begin
      w.mean_pixel = {8'hff, 8'(sr / n_frames), 8'(sg / n_frames), 8'(sb / n_frames)};
      w.last_pixel = end_frame;
      mean_q.push_back(w);
    end
    if (end_frame) begin
      pix_pos   = 0;
      frame_idx = last_frame ? 0 : ((frame_idx + 1) & 8'hff);
    end else begin
      pix_pos = (pix_pos + 1) & 32'hfffff;
    end
  endtask

  // register writes, pixels and results, all sampled at the clock edge
  always @(posedge clk) begin
    mean_word_t w;
    if (!rst_n) begin
      frames_reg <= 9'd2;
      pixels_reg <= 21'd1048576;
      pix_pos    = 0;
      frame_idx  = 0;
      mean_q.delete();
      errors     <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == fms_pkg::REG_PIXELS) pixels_reg <= pwdata[20:0];
        else frames_reg <= pwdata[8:0];
      end
      if (in_if.valid && in_if.ready)
        stack_pixel(in_if.red, in_if.green, in_if.blue, in_if.abandon);
      if (out_if.valid && out_if.ready) begin
        if (mean_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected word: mean %h last %b", out_if.mean_pixel,
                     out_if.last_pixel);
          errors <= errors + 1;
        end else begin
          w = mean_q.pop_front();
          if (w.mean_pixel !== out_if.mean_pixel || w.last_pixel !== out_if.last_pixel) begin
            if (errors < 10)
              $display("word mismatch: exp mean %h last %b, got mean %h last %b",
                       w.mean_pixel, w.last_pixel, out_if.mean_pixel, out_if.last_pixel);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the frame mean stacker.
// Directed stacks cover channel extremes, clamped register values, abandon
// and a pixel count shrunk mid-stack; random stacks follow, with random
// sender gaps and receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam logic [2:0] ADDR_FRAMES = 3'd0;
  localparam logic [2:0] ADDR_PIXELS = 3'd4;
  localparam int         DRAIN_CYC   = 25;
  localparam int         WDOG_LIMIT  = 5000;
  localparam int         ITEM_GOAL   = 1450;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          n_items;
  int          idle_cyc;
  logic        quiet, hold_go;
  logic [8:0]  frames_val;
  logic [20:0] pixels_val;

  fms_in_if  in_ch ();
  fms_out_if out_ch ();

  frame_mean_stacker u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fms_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: cycles with no handshake on any port
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    bit held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_go && !held) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_FRAMES) frames_val = data[8:0];
    else pixels_val = data[20:0];
  endtask

  // one pixel word; valid stays high across back-to-back words
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic ab);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.red     <= r;
    in_ch.green   <= g;
    in_ch.blue    <= b;
    in_ch.abandon <= ab;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (n_items > 400) hold_go = 1'b1;
    if (n_items > ITEM_GOAL - 150) quiet = 1'b1;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // full stacks at the current register values, abandon noise in percent
  task automatic run_stacks(input int stacks, input int ab_pct);
    int nf, np;
    nf = (frames_val < 2) ? 2 : (frames_val > 256) ? 256 : frames_val;
    np = (pixels_val == 0) ? 1 : pixels_val;
    for (int s = 0; s < stacks; s++) begin
      for (int f = 0; f < nf; f++) begin
        for (int p = 0; p < np; p++) begin
          if (n_items >= ITEM_GOAL) return;
          if ($urandom_range(0, 99) < ab_pct) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            f = nf;
            break;
          end
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        end
      end
    end
  endtask

  initial begin
    int pick;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.red     <= '0;
    in_ch.green   <= '0;
    in_ch.blue    <= '0;
    in_ch.abandon <= 1'b0;
    n_items       = 0;
    quiet         = 1'b0;
    hold_go       = 1'b0;
    frames_val    = 9'd2;
    pixels_val    = 21'd1048576;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // oversized pixel count: a few words of frame 0, then abandon
    reg_write(ADDR_PIXELS, 32'd2000000);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(8'd4, 8'd5, 8'd6, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    drain();

    // clamped low registers: N of 0 and pixel count of 0, channel extremes
    reg_write(ADDR_FRAMES, 32'd0);
    reg_write(ADDR_PIXELS, 32'd0);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_pixel(8'hff, 8'h00, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    // abandon mid-stack, then a fresh stack
    send_pixel(8'h80, 8'h40, 8'h20, 1'b0);
    send_pixel(8'h11, 8'h22, 8'h33, 1'b1);
    send_pixel(8'h7f, 8'h01, 8'hfe, 1'b0);
    send_pixel(8'h01, 8'h7f, 8'hfe, 1'b0);
    drain();

    // N of 1 counts as 2; then pixel count shrinks during frame 1 of 3
    reg_write(ADDR_FRAMES, 32'd1);
    reg_write(ADDR_PIXELS, 32'd2);
    run_stacks(1, 0);
    drain();
    reg_write(ADDR_FRAMES, 32'd3);
    reg_write(ADDR_PIXELS, 32'd4);
    for (int i = 0; i < 6; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    drain();
    reg_write(ADDR_PIXELS, 32'd2);
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    drain();

    // random register settings and stacks
    while (n_items < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) reg_write(ADDR_FRAMES, $urandom_range(2, 4));
      else if (pick < 80) reg_write(ADDR_FRAMES, $urandom_range(0, 1));
      else if (pick < 92) reg_write(ADDR_FRAMES, $urandom_range(5, 16));
      else if (pick < 96) reg_write(ADDR_FRAMES, 256);
      else reg_write(ADDR_FRAMES, $urandom_range(257, 511));
      if (frames_val > 16) reg_write(ADDR_PIXELS, 1);
      else if ($urandom_range(0, 9) == 0) reg_write(ADDR_PIXELS, 0);
      else reg_write(ADDR_PIXELS, $urandom_range(1, 8));
      run_stacks($urandom_range(1, 3), ($urandom_range(0, 3) == 0) ? 3 : 0);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
